### design/extended_round_to_integral_macros.svh
// Assertion macros for the extended round-to-integral block.
// Used by extended_round_to_integral.sv; no other dependencies.
`ifndef EXTENDED_ROUND_TO_INTEGRAL_MACROS_SVH
`define EXTENDED_ROUND_TO_INTEGRAL_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ERI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ERI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/eri_pkg.sv
// Package for the extended round-to-integral block: rounding mode codes and
// format constants. No dependencies.
package eri_pkg;
    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_DOWN    = 2'd1,
        RM_UP      = 2'd2,
        RM_ZERO    = 2'd3
    } round_mode_t;
    localparam logic [14:0] EXP_BIAS = 15'd16383;
    localparam logic [14:0] EXP_MAX  = 15'h7FFF;
    localparam logic [14:0] EXP_BIG  = 15'd16446;  // bias + 63
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h4000_0000_0000_0000;
endpackage

### design/extended_round_to_integral.sv
// Extended round-to-integral: rounds one 80-bit extended value to an integer
// under the configured rounding mode, with inexact and invalid flags. Takes
// one word per clock while s_ready is high; an accepted word's result is
// registered into the output register, or into the skid register while the
// output is stalled; the rounding itself is one pass of mask and add logic.
// One more word can be caught in the skid register; after that s_ready drops until the output register drains.
// Depends on eri_pkg and extended_round_to_integral_macros.svh.
`include "extended_round_to_integral_macros.svh"
module extended_round_to_integral (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_in_sign,
    input  logic [14:0] s_in_exponent,
    input  logic [63:0] s_in_mantissa,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_sign,
    output logic [14:0] m_out_exponent,
    output logic [63:0] m_out_mantissa,
    output logic        m_inexact,
    output logic        m_invalid
);
    import eri_pkg::*;

    typedef struct packed {
        logic        sign;
        logic [14:0] exponent;
        logic [63:0] mantissa;
        logic        inexact;
        logic        invalid;
    } result_t;

    round_mode_t mode_reg;
    result_t     res_next, out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    // rounding datapath
    logic [5:0]  fbits;
    logic [63:0] fmask, frac, gmask, base, step, sum;
    logic [64:0] sum_w;
    logic        guard, sticky, lsb, inc, one;
    logic [14:0] ediff;

    always_comb begin
        ediff = s_in_exponent - EXP_BIAS;
        fbits = 6'd63 - ediff[5:0];
        fmask = (64'd1 << fbits) - 64'd1;
        gmask = fmask >> 1;
        frac  = s_in_mantissa & fmask;
        guard = |(frac & ~gmask);
        sticky = |(frac & gmask);
        lsb   = |(s_in_mantissa & (fmask + 64'd1));
        base  = s_in_mantissa & ~fmask;
        step  = fmask + 64'd1;
        sum_w = {1'b0, base} + {1'b0, step};
        sum   = sum_w[63:0];
        case (mode_reg)
            RM_NEAREST: inc = guard && (sticky || lsb);
            RM_DOWN:    inc = s_in_sign;
            RM_UP:      inc = !s_in_sign;
            default:    inc = 1'b0;
        endcase
        case (mode_reg)
            RM_NEAREST: one = (s_in_exponent == EXP_BIAS - 15'd1) && (s_in_mantissa > TOP_BIT);
            RM_DOWN:    one = s_in_sign;
            RM_UP:      one = !s_in_sign;
            default:    one = 1'b0;
        endcase

        res_next.sign     = s_in_sign;
        res_next.exponent = s_in_exponent;
        res_next.mantissa = s_in_mantissa;
        res_next.inexact  = 1'b0;
        res_next.invalid  = 1'b0;
        if (s_in_exponent >= EXP_BIG) begin
            if (s_in_exponent == EXP_MAX && (s_in_mantissa[62:0] != 63'd0)) begin
                res_next.invalid  = !s_in_mantissa[62];
                res_next.mantissa = s_in_mantissa | QUIET_BIT;
            end
        end else if (s_in_mantissa == 64'd0) begin
            res_next.mantissa = s_in_mantissa;
        end else if (s_in_exponent < EXP_BIAS) begin
            res_next.inexact  = 1'b1;
            res_next.exponent = one ? EXP_BIAS : 15'd0;
            res_next.mantissa = one ? TOP_BIT : 64'd0;
        end else if (frac != 64'd0) begin
            res_next.inexact = 1'b1;
            if (!inc) begin
                res_next.mantissa = base;
            end else if (sum_w[64]) begin
                res_next.mantissa = TOP_BIT;
                res_next.exponent = s_in_exponent + 15'd1;
            end else begin
                res_next.mantissa = sum;
            end
        end
    end

    logic s_acc;
    assign s_ready = !skid_valid_reg;
    assign s_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= RM_NEAREST;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= round_mode_t'(cfg_data);
            end
            if (!out_valid_reg || m_ready) begin
                out_valid_reg  <= skid_valid_reg || s_acc;
                skid_valid_reg <= 1'b0;
            end else if (s_acc) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end else if (s_acc) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_sign     = out_reg.sign;
    assign m_out_exponent = out_reg.exponent;
    assign m_out_mantissa = out_reg.mantissa;
    assign m_inexact      = out_reg.inexact;
    assign m_invalid      = out_reg.invalid;

    `ERI_ASSERT_IMP(a_skid_implies_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ERI_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_reg))
    `ERI_ASSERT_IMP(a_flags_exclusive, aclk, aresetn, m_valid, !(m_inexact && m_invalid))
endmodule
